>>> rtl/core/rmm_pkg.sv
package rmm_pkg;

  localparam int ELEM_W   = 16;
  localparam int IDX_W    = 7;
  localparam int CNT_W    = 8;
  localparam int BEAT_W   = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int HALF_W   = 16;

  localparam logic REG_ELEMENT_MODE = 1'b0;
  localparam logic REG_ROW_DEPTH    = 1'b1;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_HALF = 1'b1;

  localparam logic [CNT_W-1:0]  DEPTH_RST = 8'd128;
  localparam logic [ELEM_W-1:0] MIN_RST_BYTE = 16'h00FF;
  localparam logic [ELEM_W-1:0] MIN_RST_HALF = 16'hFFFF;

  typedef struct packed {
    logic              vld;
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } lane_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } best_t;

  typedef struct packed {
    best_t max;
    best_t min;
  } result_t;

endpackage

>>> rtl/core/rmm_lane.sv
module rmm_lane #(
  parameter int LANE      = 0,
  parameter int BEAT_BITS = 64
) (
  input  logic [rmm_pkg::BEAT_W-1:0] beat_data_i,
  input  logic                       mode_i,
  input  logic [rmm_pkg::CNT_W-1:0]  seen_i,
  input  logic [rmm_pkg::CNT_W-1:0]  depth_i,
  output rmm_pkg::lane_t             lane_o
);

  localparam int LANES16 = BEAT_BITS / rmm_pkg::HALF_W;

  logic [rmm_pkg::ELEM_W-1:0] byte_val;
  logic [rmm_pkg::ELEM_W-1:0] half_val;
  logic                       half_ok;
  logic [rmm_pkg::CNT_W:0]    pos;

  assign byte_val = {{(rmm_pkg::ELEM_W-rmm_pkg::BYTE_W){1'b0}},
                     beat_data_i[LANE*rmm_pkg::BYTE_W +: rmm_pkg::BYTE_W]};

  if (LANE < LANES16) begin : g_half
    assign half_val = beat_data_i[LANE*rmm_pkg::HALF_W +: rmm_pkg::HALF_W];
    assign half_ok  = 1'b1;
  end else begin : g_no_half
    assign half_val = '0;
    assign half_ok  = 1'b0;
  end

  assign pos = {1'b0, seen_i} + (rmm_pkg::CNT_W+1)'(LANE);

  always_comb begin
    lane_o.value = (mode_i == rmm_pkg::MODE_HALF) ? half_val : byte_val;
    lane_o.index = pos[rmm_pkg::IDX_W-1:0];
    lane_o.vld   = (pos < {1'b0, depth_i}) &&
                   ((mode_i == rmm_pkg::MODE_BYTE) || half_ok);
  end

endmodule

>>> rtl/core/rmm_merge.sv
module rmm_merge #(
  parameter int LANES = 8
) (
  input  rmm_pkg::best_t              max_run_i,
  input  rmm_pkg::best_t              min_run_i,
  input  rmm_pkg::lane_t [LANES-1:0]  lanes_i,
  output rmm_pkg::best_t              max_o,
  output rmm_pkg::best_t              min_o
);

  localparam int NODES = 1 << $clog2(LANES);

  rmm_pkg::lane_t [NODES-1:0] max_tree;
  rmm_pkg::lane_t [NODES-1:0] min_tree;

  // pairwise tree; the lower node always holds the earlier index, so ties keep it
  always_comb begin
    max_tree = '0;
    min_tree = '0;
    for (int i = 0; i < LANES; i++) begin
      max_tree[i] = lanes_i[i];
      min_tree[i] = lanes_i[i];
    end
    for (int s = 1; s < NODES; s = s * 2) begin
      for (int i = 0; i < NODES; i += 2 * s) begin
        if (max_tree[i+s].vld &&
            (!max_tree[i].vld || (max_tree[i+s].value > max_tree[i].value))) begin
          max_tree[i] = max_tree[i+s];
        end
        if (min_tree[i+s].vld &&
            (!min_tree[i].vld || (min_tree[i+s].value < min_tree[i].value))) begin
          min_tree[i] = min_tree[i+s];
        end
      end
    end

    max_o = max_run_i;
    min_o = min_run_i;
    if (max_tree[0].vld && (max_tree[0].value > max_run_i.value)) begin
      max_o.value = max_tree[0].value;
      max_o.index = max_tree[0].index;
    end
    if (min_tree[0].vld && (min_tree[0].value < min_run_i.value)) begin
      min_o.value = min_tree[0].value;
      min_o.index = min_tree[0].index;
    end
  end

endmodule

>>> rtl/core/row_argmin_argmax_core.sv
// Channel  | Handshake                   | Payload
// beat in  | beat_valid_i / beat_stall_o | beat_data_i
// result   | res_valid_o / res_stall_i   | max_value_o, max_index_o, min_value_o, min_index_o
// config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
// One beat per cycle while not stalled; all lanes compare with the running state combinationally.
// A result is registered into the output or skid register from the beat that completes its row.
// A two-entry output buffer absorbs result stalls; beat_stall_o rises only when both are full.
// Reset zeroes the count and running max, sets the running min to 0x00FF, 8-bit mode, depth 128.
module row_argmin_argmax_core #(
  parameter int MAX_DEPTH = 128,
  parameter int BEAT_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             beat_valid_i,
  output logic                             beat_stall_o,
  input  logic [rmm_pkg::BEAT_W-1:0]       beat_data_i,

  output logic                             res_valid_o,
  input  logic                             res_stall_i,
  output logic [rmm_pkg::ELEM_W-1:0]       max_value_o,
  output logic [rmm_pkg::IDX_W-1:0]        max_index_o,
  output logic [rmm_pkg::ELEM_W-1:0]       min_value_o,
  output logic [rmm_pkg::IDX_W-1:0]        min_index_o,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rmm_pkg::ADDR_W-1:0]       paddr,
  input  logic [rmm_pkg::DATA_W-1:0]       pwdata,
  output logic [rmm_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int LANES8  = BEAT_BITS / rmm_pkg::BYTE_W;
  localparam int LANES16 = BEAT_BITS / rmm_pkg::HALF_W;
  localparam int LIM_W   = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W   = (LIM_W > rmm_pkg::CNT_W) ? LIM_W : rmm_pkg::CNT_W;
  localparam logic [CMP_W-1:0] LIMIT8  = CMP_W'(MAX_DEPTH);
  localparam logic [CMP_W-1:0] LIMIT16 = CMP_W'(MAX_DEPTH / 2);

  logic                       mode_q;
  logic [rmm_pkg::CNT_W-1:0]  depth_q;
  logic [rmm_pkg::CNT_W-1:0]  seen_q, seen_d;
  rmm_pkg::best_t             max_q, max_d, min_q, min_d;
  rmm_pkg::result_t           out_q, skid_q;
  logic                       out_valid_q, skid_valid_q;

  logic                       cfg_wr;
  logic                       new_mode;
  logic                       beat_acc, pop;
  logic [CMP_W-1:0]           limit, depth_ext, capped;
  logic [rmm_pkg::CNT_W-1:0]  eff_depth;
  logic [rmm_pkg::CNT_W:0]    seen_next;
  logic                       row_done;
  rmm_pkg::lane_t [LANES8-1:0] lanes;
  rmm_pkg::best_t             max_m, min_m;
  rmm_pkg::result_t           push_res;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign new_mode = (cfg_wr && (paddr[2] == rmm_pkg::REG_ELEMENT_MODE)) ? pwdata[0] : mode_q;

  always_comb begin
    unique case (paddr[2])
      rmm_pkg::REG_ELEMENT_MODE: prdata = {{(rmm_pkg::DATA_W-1){1'b0}}, mode_q};
      rmm_pkg::REG_ROW_DEPTH:
        prdata = {{(rmm_pkg::DATA_W-rmm_pkg::CNT_W){1'b0}}, depth_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rmm_pkg::MODE_BYTE;
      depth_q <= rmm_pkg::DEPTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rmm_pkg::REG_ELEMENT_MODE: mode_q  <= pwdata[0];
        rmm_pkg::REG_ROW_DEPTH:    depth_q <= pwdata[rmm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    limit     = (mode_q == rmm_pkg::MODE_HALF) ? LIMIT16 : LIMIT8;
    depth_ext = CMP_W'(depth_q);
    capped    = (depth_ext > limit) ? limit : depth_ext;
    eff_depth = capped[rmm_pkg::CNT_W-1:0];
    if (eff_depth == '0) begin
      eff_depth = {{(rmm_pkg::CNT_W-1){1'b0}}, 1'b1};
    end
  end

  for (genvar g = 0; g < LANES8; g++) begin : g_lane
    rmm_lane #(
      .LANE      (g),
      .BEAT_BITS (BEAT_BITS)
    ) u_lane (
      .beat_data_i (beat_data_i),
      .mode_i      (mode_q),
      .seen_i      (seen_q),
      .depth_i     (eff_depth),
      .lane_o      (lanes[g])
    );
  end

  rmm_merge #(
    .LANES (LANES8)
  ) u_merge (
    .max_run_i (max_q),
    .min_run_i (min_q),
    .lanes_i   (lanes),
    .max_o     (max_m),
    .min_o     (min_m)
  );

  assign beat_stall_o = skid_valid_q;
  assign beat_acc     = beat_valid_i && !beat_stall_o;
  assign seen_next    = {1'b0, seen_q} + ((mode_q == rmm_pkg::MODE_HALF) ?
                        (rmm_pkg::CNT_W+1)'(LANES16) : (rmm_pkg::CNT_W+1)'(LANES8));
  assign row_done     = seen_next >= {1'b0, eff_depth};
  assign push_res     = '{max: max_m, min: min_m};

  always_comb begin
    seen_d = seen_q;
    max_d  = max_q;
    min_d  = min_q;
    if (cfg_wr || (beat_acc && row_done)) begin
      seen_d      = '0;
      max_d       = '0;
      min_d.index = '0;
      min_d.value = (new_mode == rmm_pkg::MODE_HALF) ? rmm_pkg::MIN_RST_HALF
                                                     : rmm_pkg::MIN_RST_BYTE;
    end else if (beat_acc) begin
      seen_d = seen_next[rmm_pkg::CNT_W-1:0];
      max_d  = max_m;
      min_d  = min_m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      max_q       <= '0;
      min_q.value <= rmm_pkg::MIN_RST_BYTE;
      min_q.index <= '0;
    end else begin
      seen_q <= seen_d;
      max_q  <= max_d;
      min_q  <= min_d;
    end
  end

  assign pop = out_valid_q && !res_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (beat_acc && row_done && !cfg_wr) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (beat_acc && row_done && !cfg_wr) begin
      if (out_valid_q && !pop) begin
        skid_q <= push_res;
      end else begin
        out_q <= push_res;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign max_value_o = out_q.max.value;
  assign max_index_o = out_q.max.index;
  assign min_value_o = out_q.min.value;
  assign min_index_o = out_q.min.index;

endmodule
